// ===== hw/rtl/qcl_pkg.sv =====
// Package for the quantile colour lookup: table geometry, field widths,
// function codes, state encoding and the structs passed to the table store.
// Depends on nothing; every other file of the block imports it.
package qcl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W      = 1;
  localparam int ENTRY_W     = 8;
  localparam int VALUE_W     = 32;
  localparam int COLOUR_W    = 8;
  localparam int CFG_W       = 9;
  localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0] MAP_ENTRIES_RESET = CFG_W'(256);

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } qcl_state_t;

  typedef struct packed {
    logic                      en;
    logic [IDX_W-1:0]          addr;
    logic signed [VALUE_W-1:0] data;
  } qcl_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr0;
    logic [IDX_W-1:0] addr1;
  } qcl_rd_t;

endpackage

// ===== hw/rtl/qcl_req_if.sv =====
// Request channel interface: valid/ready handshake with the request payload.
// Depends on qcl_pkg for the field widths.
interface qcl_req_if
  import qcl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [ENTRY_W-1:0]        entry_index;
  logic signed [VALUE_W-1:0] sample_value;

  modport source (output valid, output func, output entry_index, output sample_value,
                  input ready);
  modport sink   (input valid, input func, input entry_index, input sample_value,
                  output ready);
endinterface

// ===== hw/rtl/qcl_res_if.sv =====
// Result channel interface: valid/ready handshake with the colour index.
// Depends on qcl_pkg for the field width.
interface qcl_res_if
  import qcl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] colour_index;

  modport source (output valid, output colour_index, input ready);
  modport sink   (input valid, input colour_index, output ready);
endinterface

// ===== hw/rtl/qcl_table.sv =====
// Threshold store: one write port and two read ports, read data registered.
// Depends on qcl_pkg for the depth, widths and port structs.
module qcl_table
  import qcl_pkg::*;
(
  input  logic                      clk,
  input  qcl_wr_t                   wr,
  input  qcl_rd_t                   rd,
  output logic signed [VALUE_W-1:0] rd_data0,
  output logic signed [VALUE_W-1:0] rd_data1
);

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A read may address the entry being written in the same cycle: the
  // sequencer only writes while it is idle, and the data read then is not used.
  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd.addr0];
    rd_data1 <= mem[rd.addr1];
  end

endmodule

// ===== hw/rtl/quantile_colour_lookup_top.sv =====
// Top level of the quantile colour lookup: request sequencer, binary range
// search and result register. Depends on qcl_pkg, qcl_req_if, qcl_res_if, qcl_table.
//
//   Channel   Direction  Handshake           Payload
//   in_ch     in         valid/ready         func, entry_index, sample_value
//   out_ch    out        valid/ready         colour_index
//   cfg_*     in         write enable only   map_entries (cfg_wdata)
//
// A write request is taken while the sequencer is idle. A lookup request runs
// k search steps (one to eight for a 256-entry table, that is at most
// ceil(log2(map_entries))) on registered read data from the threshold store:
// each step compares the two entries fetched by the previous step (the first
// pair on acceptance) and issues the next pair of reads. A lookup over one
// entry skips the search. Reset sends the sequencer to idle, clears the result
// valid flag and sets map_entries to 256; the table is undefined until written.
// A stall on the result side holds the finished index in the sequencer until
// the result register frees, and no new request is taken meanwhile.
module quantile_colour_lookup_top
  import qcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  qcl_req_if.sink           in_ch,
  qcl_res_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Configuration register.
  logic [CFG_W-1:0] map_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_entries_r <= MAP_ENTRIES_RESET;
    end else if (cfg_we) begin
      map_entries_r <= cfg_wdata;
    end
  end

  // Highest table index the search may use: map_entries clamped into the
  // range one to TABLE_DEPTH, less one.
  logic [CMP_W-1:0] entries_ext;
  logic [IDX_W-1:0] hi_start;

  always_comb begin
    entries_ext = CMP_W'(map_entries_r);
    if (entries_ext == '0) begin
      hi_start = '0;
    end else if (entries_ext > CMP_W'(TABLE_DEPTH)) begin
      hi_start = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      hi_start = IDX_W'(entries_ext - CMP_W'(1));
    end
  end

  // Sequencer state and search registers.
  qcl_state_t                state_r, state_nxt;
  logic [IDX_W-1:0]          lo_r, lo_nxt;
  logic [IDX_W-1:0]          hi_r, hi_nxt;
  logic [IDX_W-1:0]          mid_r, mid_nxt;
  logic [IDX_W-1:0]          res_r, res_nxt;
  logic signed [VALUE_W-1:0] x_r, x_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [COLOUR_W-1:0]       out_colour_r, out_colour_nxt;

  qcl_wr_t                   tbl_wr;
  qcl_rd_t                   tbl_rd;
  logic signed [VALUE_W-1:0] rd_data0;
  logic signed [VALUE_W-1:0] rd_data1;

  qcl_table u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  logic accept;
  logic is_lookup;
  logic out_free;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_lookup = (in_ch.func == FUNC_LOOKUP);
  assign out_free  = !out_valid_r || out_ch.ready;

  // One search step. rd_data0 holds entry mid and rd_data1 entry mid + 1,
  // both fetched in the previous cycle.
  logic             step_gt;
  logic             step_le;
  logic             step_found;
  logic [IDX_W-1:0] step_lo;
  logic [IDX_W-1:0] step_hi;
  logic             step_done;
  logic [IDX_W:0]   step_sum;
  logic [IDX_W:0]   start_sum;

  always_comb begin
    step_gt    = rd_data0 > x_r;
    step_le    = rd_data1 <= x_r;
    step_found = 1'b0;
    step_lo    = lo_r;
    step_hi    = hi_r;
    if (step_gt) begin
      step_hi = mid_r;
    end else if (step_le) begin
      step_lo = mid_r + IDX_W'(1);
    end else begin
      step_found = 1'b1;
    end
    step_done = step_found || !(step_lo < step_hi);
    step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
    start_sum = {1'b0, hi_start};
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_lookup) begin
          state_nxt = (hi_start == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (step_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    in_ch.ready    = 1'b0;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_nxt        = res_r;
    x_nxt          = x_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_colour_nxt = out_colour_r;
    tbl_wr.en      = 1'b0;
    tbl_wr.addr    = IDX_W'(in_ch.entry_index);
    tbl_wr.data    = in_ch.sample_value;
    tbl_rd.addr0   = mid_r;
    tbl_rd.addr1   = mid_r + IDX_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          if (is_lookup) begin
            x_nxt   = in_ch.sample_value;
            lo_nxt  = '0;
            hi_nxt  = hi_start;
            res_nxt = '0;
            mid_nxt = start_sum[IDX_W:1];
            tbl_rd.addr0 = start_sum[IDX_W:1];
            tbl_rd.addr1 = start_sum[IDX_W:1] + IDX_W'(1);
          end else begin
            // Positions beyond the table are dropped.
            tbl_wr.en = (32'(in_ch.entry_index) < TABLE_DEPTH);
          end
        end
      end
      ST_SEARCH: begin
        lo_nxt  = step_lo;
        hi_nxt  = step_hi;
        res_nxt = step_found ? mid_r : step_lo;
        mid_nxt = step_sum[IDX_W:1];
        tbl_rd.addr0 = step_sum[IDX_W:1];
        tbl_rd.addr1 = step_sum[IDX_W:1] + IDX_W'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_colour_nxt = COLOUR_W'(res_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_r        <= res_nxt;
    x_r          <= x_nxt;
    out_colour_r <= out_colour_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.colour_index = out_colour_r;

endmodule
